[rtl/core/gap_pkg.sv]
// Shared constants for the greedy assignment picker.
package gap_pkg;

    localparam int DEF_MAX_PARTIES = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    // Fixed field widths at the ports.
    localparam int IDX_FIELD_W = 5;
    localparam int WGT_FIELD_W = 16;
    localparam int TOT_FIELD_W = 21;
    localparam int CNT_REG_W   = 6;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 48;

    // Input item kinds carried on tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef logic [CNT_REG_W-1:0] t_count_reg;

endpackage

[rtl/core/gap_ram.sv]
// Generic single-port RAM with a registered read.
module gap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/greedy_assignment_picker_core.sv]
// Greedy assignment picker: weight memory, round scanner and result register.
// Write items are accepted back to back while idle.
// A start item runs min(rows, cols) rounds; each round reads the active rows x cols
// of the weight memory at one entry per cycle, then passes a wait state for the read
// latency and an emit state, which holds while the output is stalled.
// Reset clears control state, used bits and total, sets both counts to 32; the weight
// memory is not cleared and must be written before it is used.
module greedy_assignment_picker_core
    import gap_pkg::*;
#(
    parameter int MAX_PARTIES = DEF_MAX_PARTIES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CNT_REG_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: row_index [4:0], col_index [9:5], weight [25:10], zero fill above.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op [0].
    input  logic                  s_axis_tuser,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: picked_row [4:0], picked_col [9:5], picked_weight [25:10],
    // running_total [46:26], zero fill [47].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int IDX_W  = (MAX_PARTIES > 2) ? $clog2(MAX_PARTIES) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTIES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int EXT_W  = 7;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                    r_state;
    t_count_reg                    r_row_count;
    t_count_reg                    r_col_count;
    logic [IDX_W-1:0]              r_last_row;
    logic [IDX_W-1:0]              r_last_col;
    logic [CNT_W-1:0]              r_rounds_left;
    logic [IDX_W-1:0]              r_scan_row;
    logic [IDX_W-1:0]              r_scan_col;
    logic [MAX_PARTIES-1:0]        r_row_used;
    logic [MAX_PARTIES-1:0]        r_col_used;
    logic                          r_rd_valid;
    logic [IDX_W-1:0]              r_rd_row;
    logic [IDX_W-1:0]              r_rd_col;
    logic                          r_found;
    logic signed [WEIGHT_BITS-1:0] r_best_w;
    logic [IDX_W-1:0]              r_best_row;
    logic [IDX_W-1:0]              r_best_col;
    logic [TOT_FIELD_W-1:0]        r_total;
    logic                          r_out_valid;
    logic                          r_out_last;
    logic [OUT_DATA_W-1:0]         r_out_data;

    logic                          in_acc;
    logic                          is_start;
    logic [IDX_FIELD_W-1:0]        in_row;
    logic [IDX_FIELD_W-1:0]        in_col;
    logic signed [WGT_FIELD_W-1:0] in_weight;
    logic [EXT_W-1:0]              in_row7;
    logic [EXT_W-1:0]              in_col7;
    logic                          wr_in_range;
    logic signed [31:0]            in_weight32;
    logic [EXT_W-1:0]              rows7;
    logic [EXT_W-1:0]              cols7;
    logic [EXT_W-1:0]              rounds7;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [WEIGHT_BITS-1:0]        ram_wdata;
    logic [WEIGHT_BITS-1:0]        ram_rdata;
    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic                          take;
    logic                          scan_end;
    logic                          emit_go;
    logic signed [31:0]            best32;
    logic [TOT_FIELD_W-1:0]        n_total;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign is_start  = (s_axis_tuser == OP_START);
    assign in_row    = s_axis_tdata[IDX_FIELD_W-1:0];
    assign in_col    = s_axis_tdata[2*IDX_FIELD_W-1:IDX_FIELD_W];
    assign in_weight = s_axis_tdata[2*IDX_FIELD_W+WGT_FIELD_W-1:2*IDX_FIELD_W];
    assign in_row7   = {2'b00, in_row};
    assign in_col7   = {2'b00, in_col};
    assign wr_in_range = (in_row7 < EXT_W'(MAX_PARTIES)) && (in_col7 < EXT_W'(MAX_PARTIES));
    assign in_weight32 = 32'(in_weight);

    // Counts above the array size are taken as the array size.
    assign rows7 = ({1'b0, r_row_count} > EXT_W'(MAX_PARTIES)) ?
                   EXT_W'(MAX_PARTIES) : {1'b0, r_row_count};
    assign cols7 = ({1'b0, r_col_count} > EXT_W'(MAX_PARTIES)) ?
                   EXT_W'(MAX_PARTIES) : {1'b0, r_col_count};
    assign rounds7 = (rows7 < cols7) ? rows7 : cols7;

    assign ram_we    = in_acc && !is_start && wr_in_range;
    assign ram_wdata = in_weight32[WEIGHT_BITS-1:0];
    assign ram_addr  = (r_state == ST_SCAN) ? {r_scan_row, r_scan_col}
                                            : {in_row7[IDX_W-1:0], in_col7[IDX_W-1:0]};

    gap_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_w = ram_rdata;
    // Ties keep the smallest column, and rows arrive in ascending order.
    assign take = r_rd_valid &&
                  (!r_found || (rd_w > r_best_w) ||
                   ((rd_w == r_best_w) && (r_rd_col < r_best_col)));
    assign scan_end = (r_scan_row == r_last_row) && (r_scan_col == r_last_col);
    assign emit_go  = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign best32   = 32'(r_best_w);
    assign n_total  = r_total + best32[TOT_FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= t_count_reg'(32);
            r_col_count <= t_count_reg'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                REG_COL_COUNT: r_col_count <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rounds_left <= '0;
            r_scan_row    <= '0;
            r_scan_col    <= '0;
            r_row_used    <= '0;
            r_col_used    <= '0;
            r_rd_valid    <= 1'b0;
            r_found       <= 1'b0;
            r_total       <= '0;
        end else begin
            r_rd_valid <= (r_state == ST_SCAN) && !r_row_used[r_scan_row]
                          && !r_col_used[r_scan_col];
            if (take) begin
                r_found <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && is_start) begin
                        r_row_used    <= '0;
                        r_col_used    <= '0;
                        r_total       <= '0;
                        r_found       <= 1'b0;
                        r_scan_row    <= '0;
                        r_scan_col    <= '0;
                        r_rounds_left <= CNT_W'(rounds7);
                        if (rounds7 != '0) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_end) begin
                        r_state <= ST_WAIT;
                    end else if (r_scan_col == r_last_col) begin
                        r_scan_col <= '0;
                        r_scan_row <= r_scan_row + 1'b1;
                    end else begin
                        r_scan_col <= r_scan_col + 1'b1;
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_row_used[r_best_row] <= 1'b1;
                        r_col_used[r_best_col] <= 1'b1;
                        r_total       <= n_total;
                        r_rounds_left <= r_rounds_left - 1'b1;
                        r_found       <= 1'b0;
                        r_scan_row    <= '0;
                        r_scan_col    <= '0;
                        r_state       <= (r_rounds_left == CNT_W'(1)) ? ST_IDLE : ST_SCAN;
                    end
                end
            endcase
        end
    end

    // Payload registers of the scan.
    always_ff @(posedge i_clk) begin
        r_rd_row <= r_scan_row;
        r_rd_col <= r_scan_col;
        if (take) begin
            r_best_w   <= rd_w;
            r_best_row <= r_rd_row;
            r_best_col <= r_rd_col;
        end
        if ((r_state == ST_IDLE) && in_acc && is_start) begin
            r_last_row <= IDX_W'(rows7 - EXT_W'(1));
            r_last_col <= IDX_W'(cols7 - EXT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_last <= (r_rounds_left == CNT_W'(1));
            r_out_data <= {1'b0, n_total, best32[WGT_FIELD_W-1:0],
                           IDX_FIELD_W'(r_best_col), IDX_FIELD_W'(r_best_row)};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Every round marks exactly one row and one column.
    a_used_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_row_used) == $countones(r_col_used))
        else $error("row and column used bits out of step");

    // A round never ends without a candidate.
    a_emit_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_found)
        else $error("round ended with no candidate");

    // No memory read is in flight once the block is idle again.
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_rd_valid)
        else $error("scan read outstanding while idle");

    // The final pick of a run returns the block to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (r_rounds_left == CNT_W'(1))) |=> (r_state == ST_IDLE))
        else $error("run did not finish after its last pick");

endmodule

[sim/greedy_assignment_picker_core_tb.sv]
// Self-checking testbench for the greedy assignment picker core.
`timescale 1ns / 100ps

module greedy_assignment_picker_core_tb;
    import gap_pkg::*;

    localparam int PARTIES        = 32;
    localparam int DRAIN_CYCLES   = 20;
    localparam int END_CYCLES     = 50;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int LIMIT_CYCLES   = 300000;
    localparam int ITEM_TARGET    = 222;

    typedef struct packed {
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] weight;
        logic signed [20:0] total;
        logic               last;
    } t_pick;

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    // One row of the directed table. A typed row carries its own expectation: either
    // nothing at all or the single pick (0, 0, typed_w) of a one-by-one matrix.
    typedef struct packed {
        t_step_kind         kind;
        logic [5:0]         rows_cfg;
        logic [5:0]         cols_cfg;
        logic               op;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] w;
        logic               typed;
        logic               typed_has;
        logic signed [15:0] typed_w;
    } t_dir_step;

    localparam int DIR_LEN = 23;
    localparam t_dir_step DIR_TAB [DIR_LEN] = '{
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd31, 5'd31, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_CFG,  6'd1,  6'd1, OP_WRITE, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b1, 1'b1, 16'sh8000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd0,  16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        // Fields of a start are ignored, so they are driven to all ones here.
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd31, 5'd31, 16'shFFFF, 1'b1, 1'b1, 16'sh7FFF},
        '{STEP_CFG,  6'd0,  6'd1, OP_WRITE, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{STEP_CFG,  6'd1,  6'd0, OP_WRITE, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{STEP_CFG,  6'd2,  6'd2, OP_WRITE, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        // Four equal weights: ties resolve by column first, then by row.
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd1,  16'sh0005, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd1,  5'd0,  16'sh0005, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd1,  5'd1,  16'sh0005, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd0,  16'sh0005, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd1,  5'd0,  16'sh0009, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd1,  5'd1,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd1,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd1,  5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_WRITE, 5'd0,  5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{STEP_ITEM, 6'd0,  6'd0, OP_START, 5'd0,  5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000}
    };

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_index   = REG_ROW_COUNT;
    logic [CNT_REG_W-1:0]  i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    greedy_assignment_picker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Mirror of the block: weights, which entries hold a value, and both counts.
    logic signed [15:0] wgt_mem     [PARTIES][PARTIES];
    bit                 wgt_written [PARTIES][PARTIES];
    logic [5:0]         rows_reg = 6'd32;
    logic [5:0]         cols_reg = 6'd32;

    t_pick expected_picks [$];
    t_pick got, want;

    int errors        = 0;
    int items_sent    = 0;
    int starts_sent   = 0;
    int picks_seen    = 0;
    int settings_done = 0;
    int cyc           = 0;
    int squeeze_left  = 0;
    bit squeeze_armed = 1'b0;
    bit squeeze_done  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_count(input logic [5:0] c);
        return (c > PARTIES) ? PARTIES : int'(c);
    endfunction

    function automatic logic signed [15:0] rand_weight();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom_range(4)) - 16'sd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // Greedy rounds over the rows and columns in use; one pick per round.
    function automatic void predict_assignment();
        logic [31:0]        rused, cused;
        logic signed [20:0] acc;
        logic signed [15:0] w, bw;
        int                 nr, nc, rounds, br, bc;
        bit                 found;
        t_pick              p;
        rused  = '0;
        cused  = '0;
        acc    = '0;
        nr     = clamp_count(rows_reg);
        nc     = clamp_count(cols_reg);
        rounds = (nr < nc) ? nr : nc;
        for (int k = 0; k < rounds; k++) begin
            found = 1'b0;
            br    = 0;
            bc    = 0;
            bw    = '0;
            for (int r = 0; r < nr; r++) begin
                if (rused[r]) continue;
                for (int c = 0; c < nc; c++) begin
                    if (cused[c]) continue;
                    w = wgt_mem[r][c];
                    if (!found || w > bw || (w == bw && c < bc)) begin
                        found = 1'b1;
                        bw    = w;
                        br    = r;
                        bc    = c;
                    end
                end
            end
            rused[br] = 1'b1;
            cused[bc] = 1'b1;
            acc       = acc + {{5{bw[15]}}, bw};
            p.row     = 5'(br);
            p.col     = 5'(bc);
            p.weight  = bw;
            p.total   = acc;
            p.last    = (k == rounds - 1);
            expected_picks.push_back(p);
        end
    endfunction

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(input logic op, input logic [4:0] r, input logic [4:0] c,
                             input logic signed [15:0] w, input bit predicted);
        while (!(items_sent >= 150 && items_sent < 200) && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, w, c, r};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (op == OP_WRITE) begin
            wgt_mem[r][c]     = w;
            wgt_written[r][c] = 1'b1;
        end else begin
            starts_sent++;
            if (predicted) predict_assignment();
        end
    endtask

    // Counts change only once the block has gone quiet.
    task automatic set_counts(input logic [5:0] r, input logic [5:0] c);
        s_axis_tvalid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_index <= REG_COL_COUNT;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = r;
        cols_reg = c;
        settings_done++;
    endtask

    // One setting: fill the region in use in random order, start, and perhaps
    // reweight a few entries and start again.
    task automatic run_phase(input logic [5:0] r, input logic [5:0] c, input bit more,
                             input bit arm_squeeze);
        int nr, nc, j, tmp;
        int cells [$];
        set_counts(r, c);
        nr = clamp_count(r);
        nc = clamp_count(c);
        repeat ($urandom_range(3))
            send_item(OP_WRITE, 5'($urandom), 5'($urandom), rand_weight(), 1'b1);
        for (int a = 0; a < nr; a++)
            for (int b = 0; b < nc; b++)
                if (!wgt_written[a][b] || nr * nc <= 16 || $urandom_range(7) == 0)
                    cells.push_back(a * PARTIES + b);
        for (int i = cells.size() - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = cells[i];
            cells[i] = cells[j];
            cells[j] = tmp;
        end
        foreach (cells[i])
            send_item(OP_WRITE, 5'(cells[i] / PARTIES), 5'(cells[i] % PARTIES),
                      rand_weight(), 1'b1);
        if (arm_squeeze) squeeze_armed = 1'b1;
        send_item(OP_START, 5'($urandom), 5'($urandom), 16'($urandom), 1'b1);
        if (more || $urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 4)) begin
                if (nr != 0 && nc != 0)
                    send_item(OP_WRITE, 5'($urandom_range(nr - 1)), 5'($urandom_range(nc - 1)),
                              rand_weight(), 1'b1);
                else
                    send_item(OP_WRITE, 5'($urandom), 5'($urandom), rand_weight(), 1'b1);
            end
            send_item(OP_START, 5'($urandom), 5'($urandom), 16'($urandom), 1'b1);
        end
    endtask

    // Result side: check every transfer, then choose the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row    = m_axis_tdata[4:0];
            got.col    = m_axis_tdata[9:5];
            got.weight = m_axis_tdata[25:10];
            got.total  = m_axis_tdata[46:26];
            got.last   = m_axis_tlast;
            picks_seen++;
            if (expected_picks.size() == 0) begin
                errors++;
                $display("%0t: pick with nothing expected: row %0d col %0d weight %0d total %0d last %0b",
                         $time, got.row, got.col, got.weight, got.total, got.last);
            end else begin
                want = expected_picks.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: pick mismatch: expected row %0d col %0d weight %0d total %0d last %0b",
                             $time, want.row, want.col, want.weight, want.total, want.last);
                    $display("%0t:                  actual row %0d col %0d weight %0d total %0d last %0b",
                             $time, got.row, got.col, got.weight, got.total, got.last);
                end
            end
        end
        if (squeeze_left != 0) begin
            squeeze_left--;
            m_axis_tready <= 1'b0;
        end else if (squeeze_armed && !squeeze_done && m_axis_tvalid) begin
            // Hold off long enough for the block to back up onto its input.
            squeeze_done = 1'b1;
            squeeze_left = SQUEEZE_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (picks_seen >= 70 && picks_seen < 110) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT_CYCLES) begin
            $display("%0t: timed out with %0d picks outstanding", $time, expected_picks.size());
            $display("greedy_assignment_picker_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int         mode;
        logic [5:0] r6, c6;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_LEN; k++) begin
            if (DIR_TAB[k].kind == STEP_CFG) begin
                set_counts(DIR_TAB[k].rows_cfg, DIR_TAB[k].cols_cfg);
            end else begin
                send_item(DIR_TAB[k].op, DIR_TAB[k].row, DIR_TAB[k].col, DIR_TAB[k].w,
                          !DIR_TAB[k].typed);
                if (DIR_TAB[k].typed && DIR_TAB[k].typed_has)
                    expected_picks.push_back(t_pick'{5'd0, 5'd0, DIR_TAB[k].typed_w,
                                                     {{5{DIR_TAB[k].typed_w[15]}},
                                                      DIR_TAB[k].typed_w}, 1'b1});
            end
        end

        // Counts at and beyond the top of their range, then the long receiver stall.
        run_phase(6'd63, 6'd1, 1'b0, 1'b0);
        run_phase(6'd1, 6'd40, 1'b0, 1'b0);
        run_phase(6'd32, 6'd2, 1'b0, 1'b0);
        run_phase(6'd2, 6'd32, 1'b0, 1'b0);
        run_phase(6'd4, 6'd4, 1'b1, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            mode = $urandom_range(9);
            case (mode)
                0: begin
                    r6 = 6'($urandom_range(1, 5));
                    c6 = 6'($urandom_range(1, 5));
                    if ($urandom_range(1) == 1) r6 = 6'd0;
                    else c6 = 6'd0;
                end
                1: begin
                    r6 = 6'($urandom_range(33, 63));
                    c6 = 6'($urandom_range(1, 2));
                end
                2: begin
                    r6 = 6'($urandom_range(1, 2));
                    c6 = 6'($urandom_range(32, 63));
                end
                default: begin
                    r6 = 6'($urandom_range(1, 5));
                    c6 = 6'($urandom_range(1, 5));
                end
            endcase
            run_phase(r6, c6, 1'b0, 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d transfers in, %0d of them starts, over %0d count settings;",
                 items_sent, starts_sent, settings_done);
        $display("%0d picks compared, with one long hold-off on the result side.", picks_seen);
        if (errors == 0) begin
            $display("greedy_assignment_picker_core_tb: done, clean");
        end else begin
            $display("greedy_assignment_picker_core_tb: done, errors");
        end
        $finish;
    end

endmodule
